// ----- hw/rtl/cpu_6502_cycle_stepped_core_macros.svh -----
// ----------------------------------------------------------------------------
// 6502 core assertion macros
// Shared assertion shorthands, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef CPU_6502_CYCLE_STEPPED_CORE_MACROS_SVH
`define CPU_6502_CYCLE_STEPPED_CORE_MACROS_SVH

// property holds on every edge outside reset
`define C6502_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in a cycle implies consequent in the next
`define C6502_ASSERT_NEXT(lbl, ante, cons, msg) \
	`C6502_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ----- hw/rtl/c6502_pkg.sv -----
// ----------------------------------------------------------------------------
// c6502_pkg
// Types, constants and helpers of the cycle-stepped 6502 core.
// ----------------------------------------------------------------------------
package c6502_pkg;

	localparam logic [7:0]  STACK_HI = 8'h01;
	localparam logic [15:0] IRQ_VEC  = 16'hFFFE;
	localparam logic [7:0]  RESET_A  = 8'hAA;
	localparam logic [7:0]  RESET_S  = 8'hFD;
	localparam logic [7:0]  RESET_P  = 8'h16;
	localparam logic [7:0]  PUSH_BU  = 8'h30;
	localparam logic [7:0]  PULL_MSK = 8'hCF;
	localparam logic [7:0]  FLAG_B   = 8'h10;

	typedef struct packed {
		logic [7:0] read_data;
		logic       ready_req;
	} item_t;

	typedef struct packed {
		logic [15:0] bus_address;
		logic [7:0]  write_data;
		logic        write_strobe;
		logic        opcode_fetch;
		logic        halted;
	} result_t;

	typedef enum logic [4:0] {
		M_NONE, M_IMPL, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABSX, M_ABSY,
		M_IZX, M_IZY, M_BRANCH, M_BRK, M_JSR, M_RTS, M_JMP, M_JMPI,
		M_PUSH, M_PULL
	} mode_t;

	typedef enum logic [4:0] {
		O_NONE, O_ORA, O_EOR, O_BIT, O_LDA, O_LDX, O_LDY, O_STA, O_STX,
		O_ASL, O_INC, O_CLC, O_SEC, O_CLI, O_SEI, O_CLV, O_CLD, O_SED,
		O_TAY, O_INX, O_INY, O_NOP, O_ASLA, O_A, O_P
	} op_t;

	typedef struct packed {
		mode_t mode;
		op_t   op;
	} dec_t;

	// N and Z from a result byte
	function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
		return {v[7], p[6:2], (v == 8'h00), p[0]};
	endfunction

endpackage

// ----- hw/rtl/c6502_decode.sv -----
// ----------------------------------------------------------------------------
// c6502_decode
// Opcode to addressing mode and operation; unknown opcodes give M_NONE.
// ----------------------------------------------------------------------------
module c6502_decode import c6502_pkg::*; (
	input  logic [7:0] opcode,
	output dec_t       dec
);

	always_comb begin
		case (opcode)
			8'h00: dec = '{M_BRK, O_NONE};
			8'h01: dec = '{M_IZX, O_ORA};
			8'h05: dec = '{M_ZP, O_ORA};
			8'h06: dec = '{M_ZP, O_ASL};
			8'h08: dec = '{M_PUSH, O_P};
			8'h09: dec = '{M_IMM, O_ORA};
			8'h0A: dec = '{M_IMPL, O_ASLA};
			8'h0D: dec = '{M_ABS, O_ORA};
			8'h0E: dec = '{M_ABS, O_ASL};
			8'h10: dec = '{M_BRANCH, O_NONE};
			8'h11: dec = '{M_IZY, O_ORA};
			8'h15: dec = '{M_ZPX, O_ORA};
			8'h18: dec = '{M_IMPL, O_CLC};
			8'h19: dec = '{M_ABSY, O_ORA};
			8'h1D: dec = '{M_ABSX, O_ORA};
			8'h20: dec = '{M_JSR, O_NONE};
			8'h24: dec = '{M_ZP, O_BIT};
			8'h28: dec = '{M_PULL, O_P};
			8'h2C: dec = '{M_ABS, O_BIT};
			8'h30: dec = '{M_BRANCH, O_NONE};
			8'h38: dec = '{M_IMPL, O_SEC};
			8'h41: dec = '{M_IZX, O_EOR};
			8'h45: dec = '{M_ZP, O_EOR};
			8'h48: dec = '{M_PUSH, O_A};
			8'h49: dec = '{M_IMM, O_EOR};
			8'h4C: dec = '{M_JMP, O_NONE};
			8'h4D: dec = '{M_ABS, O_EOR};
			8'h50: dec = '{M_BRANCH, O_NONE};
			8'h51: dec = '{M_IZY, O_EOR};
			8'h55: dec = '{M_ZPX, O_EOR};
			8'h58: dec = '{M_IMPL, O_CLI};
			8'h59: dec = '{M_ABSY, O_EOR};
			8'h5D: dec = '{M_ABSX, O_EOR};
			8'h60: dec = '{M_RTS, O_NONE};
			8'h68: dec = '{M_PULL, O_A};
			8'h6C: dec = '{M_JMPI, O_NONE};
			8'h70: dec = '{M_BRANCH, O_NONE};
			8'h78: dec = '{M_IMPL, O_SEI};
			8'h81: dec = '{M_IZX, O_STA};
			8'h85: dec = '{M_ZP, O_STA};
			8'h86: dec = '{M_ZP, O_STX};
			8'h90: dec = '{M_BRANCH, O_NONE};
			8'h91: dec = '{M_IZY, O_STA};
			8'hA0: dec = '{M_IMM, O_LDY};
			8'hA2: dec = '{M_IMM, O_LDX};
			8'hA4: dec = '{M_ZP, O_LDY};
			8'hA6: dec = '{M_ZP, O_LDX};
			8'hA8: dec = '{M_IMPL, O_TAY};
			8'hA9: dec = '{M_IMM, O_LDA};
			8'hAC: dec = '{M_ABS, O_LDY};
			8'hAE: dec = '{M_ABS, O_LDX};
			8'hB0: dec = '{M_BRANCH, O_NONE};
			8'hB4: dec = '{M_ZPX, O_LDY};
			8'hB6: dec = '{M_ZPY, O_LDX};
			8'hB8: dec = '{M_IMPL, O_CLV};
			8'hBC: dec = '{M_ABSX, O_LDY};
			8'hBE: dec = '{M_ABSY, O_LDX};
			8'hC8: dec = '{M_IMPL, O_INY};
			8'hD0: dec = '{M_BRANCH, O_NONE};
			8'hD8: dec = '{M_IMPL, O_CLD};
			8'hE6: dec = '{M_ZP, O_INC};
			8'hE8: dec = '{M_IMPL, O_INX};
			8'hEA: dec = '{M_IMPL, O_NOP};
			8'hEE: dec = '{M_ABS, O_INC};
			8'hF0: dec = '{M_BRANCH, O_NONE};
			8'hF6: dec = '{M_ZPX, O_INC};
			8'hF8: dec = '{M_IMPL, O_SED};
			8'hFE: dec = '{M_ABSX, O_INC};
			default: dec = '{M_NONE, O_NONE};
		endcase
	end

endmodule

// ----- hw/rtl/c6502_exec.sv -----
// ----------------------------------------------------------------------------
// c6502_exec
// Register file, sequencer and bus latches; one processor cycle per enable, unless halted or a read lacks ready_req.
// ----------------------------------------------------------------------------
module c6502_exec import c6502_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step_en,
	input  item_t   item_in,
	output result_t res
);

	logic [7:0]  a_q, x_q, y_q, s_q, p_q, opc_q, dl_q;
	logic [2:0]  step_q;
	logic [15:0] pc_q, ea_q, addr_q;
	logic        wr_q, fetch_q, stop_q;

	logic [7:0]  n_a, n_x, n_y, n_s, n_p, n_opc, n_dl;
	logic [2:0]  n_step;
	logic [15:0] n_pc, n_ea, n_addr;
	logic        n_wr, n_fetch, n_stop;

	logic [7:0]  db, opc_cur, idx, ms, lo8;
	logic [2:0]  stp, len, adv;
	logic [15:0] pc0, ea0, tmp;
	logic [8:0]  lo_sum;
	logic        flag, is_wr, is_rmw;
	dec_t        dec;

	assign db      = wr_q ? dl_q : item_in.read_data;
	assign opc_cur = fetch_q ? db : opc_q;

	c6502_decode u_dec (.opcode(opc_cur), .dec(dec));

	always_comb begin
		n_a = a_q; n_x = x_q; n_y = y_q; n_s = s_q; n_p = p_q;
		n_opc = opc_q; n_dl = dl_q; n_step = step_q; n_pc = pc_q;
		n_ea = ea_q; n_addr = addr_q; n_wr = wr_q; n_fetch = fetch_q;
		n_stop = stop_q;
		adv = 3'd1; stp = 3'd0; pc0 = '0; ea0 = '0; tmp = '0; lo_sum = '0;
		flag = 1'b0; len = 3'd5; ms = '0; lo8 = '0;
		is_wr  = (dec.op == O_STA) || (dec.op == O_STX);
		is_rmw = (dec.op == O_ASL) || (dec.op == O_INC);
		idx    = ((dec.mode == M_ZPX) || (dec.mode == M_ABSX)) ? x_q : y_q;
		if (step_en && !stop_q && (wr_q || item_in.ready_req)) begin
			n_dl = db;
			n_opc = opc_cur;
			if (fetch_q) begin
				n_step = 3'd0;
				n_fetch = 1'b0;
				n_pc = pc_q + 16'd1;
			end
			n_wr = 1'b0;
			stp = n_step;
			pc0 = n_pc;
			ea0 = ea_q;
			if (dec.mode == M_NONE) begin
				n_stop = 1'b1;
				n_addr = n_pc;
			end else begin
				case (dec.mode)
					M_IMPL: begin
						if (stp == 3'd0) begin
							n_addr = n_pc;
						end else begin
							case (dec.op)
								O_CLC: n_p[0] = 1'b0;
								O_SEC: n_p[0] = 1'b1;
								O_CLI: n_p[2] = 1'b0;
								O_SEI: n_p[2] = 1'b1;
								O_CLV: n_p[6] = 1'b0;
								O_CLD: n_p[3] = 1'b0;
								O_SED: n_p[3] = 1'b1;
								O_TAY: begin n_y = a_q; n_p = set_nz(p_q, a_q); end
								O_INX: begin
									n_x = x_q + 8'd1; n_p = set_nz(p_q, n_x);
								end
								O_INY: begin
									n_y = y_q + 8'd1; n_p = set_nz(p_q, n_y);
								end
								O_ASLA: begin
									n_a = {a_q[6:0], 1'b0};
									n_p = set_nz(p_q, n_a);
									n_p[0] = a_q[7];
								end
								default: ;
							endcase
							n_addr = n_pc; n_fetch = 1'b1;
						end
					end
					M_BRANCH: begin
						case (opc_cur[7:6])
							2'd0: flag = p_q[7];
							2'd1: flag = p_q[6];
							2'd2: flag = p_q[0];
							default: flag = p_q[1];
						endcase
						if (stp == 3'd0) begin
							n_addr = n_pc; n_pc = n_pc + 16'd1;
						end else if (stp == 3'd1) begin
							n_addr = pc0;
							n_ea = pc0 + {{8{db[7]}}, db};
							if (flag != opc_cur[5]) n_fetch = 1'b1;
						end else if (stp == 3'd2) begin
							n_addr = {pc0[15:8], ea0[7:0]};
							if (ea0[15:8] == pc0[15:8]) begin
								n_pc = ea0; n_addr = ea0; n_fetch = 1'b1;
							end
						end else begin
							n_pc = ea0; n_addr = ea0; n_fetch = 1'b1;
						end
					end
					M_BRK: begin
						case (stp)
							3'd0: n_addr = n_pc;
							3'd1: begin
								n_pc = n_pc + 16'd1;
								n_addr = {STACK_HI, s_q}; n_s = s_q - 8'd1;
								n_dl = n_pc[15:8]; n_wr = 1'b1;
							end
							3'd2: begin
								n_addr = {STACK_HI, s_q}; n_s = s_q - 8'd1;
								n_dl = n_pc[7:0]; n_wr = 1'b1;
							end
							3'd3: begin
								n_addr = {STACK_HI, s_q}; n_s = s_q - 8'd1;
								n_dl = p_q | PUSH_BU; n_wr = 1'b1;
								n_ea = IRQ_VEC;
							end
							3'd4: begin
								n_addr = ea0; n_ea = ea0 + 16'd1; n_p[2] = 1'b1;
							end
							3'd5: begin n_addr = ea0; n_ea = {8'h00, db}; end
							default: begin
								n_pc = {db, ea0[7:0]}; n_addr = n_pc; n_fetch = 1'b1;
							end
						endcase
					end
					M_JSR: begin
						case (stp)
							3'd0: begin n_addr = n_pc; n_pc = n_pc + 16'd1; end
							3'd1: begin n_addr = {STACK_HI, s_q}; n_ea = {8'h00, db}; end
							3'd2: begin
								n_addr = {STACK_HI, s_q}; n_s = s_q - 8'd1;
								n_dl = n_pc[15:8]; n_wr = 1'b1;
							end
							3'd3: begin
								n_addr = {STACK_HI, s_q}; n_s = s_q - 8'd1;
								n_dl = n_pc[7:0]; n_wr = 1'b1;
							end
							3'd4: n_addr = n_pc;
							default: begin
								n_pc = {db, ea0[7:0]}; n_addr = n_pc; n_fetch = 1'b1;
							end
						endcase
					end
					M_RTS: begin
						case (stp)
							3'd0: n_addr = n_pc;
							3'd1, 3'd2: begin
								n_addr = {STACK_HI, s_q}; n_s = s_q + 8'd1;
							end
							3'd3: begin n_addr = {STACK_HI, s_q}; n_ea = {8'h00, db}; end
							3'd4: begin
								n_addr = {db, ea0[7:0]}; n_pc = n_addr + 16'd1;
							end
							default: begin n_addr = n_pc; n_fetch = 1'b1; end
						endcase
					end
					M_JMP: begin
						if (stp == 3'd0) begin
							n_addr = n_pc; n_pc = n_pc + 16'd1;
						end else if (stp == 3'd1) begin
							n_addr = n_pc; n_pc = n_pc + 16'd1; n_ea = {8'h00, db};
						end else begin
							n_pc = {db, ea0[7:0]}; n_addr = n_pc; n_fetch = 1'b1;
						end
					end
					M_JMPI: begin
						case (stp)
							3'd0: begin n_addr = n_pc; n_pc = n_pc + 16'd1; end
							3'd1: begin
								n_addr = n_pc; n_pc = n_pc + 16'd1; n_ea = {8'h00, db};
							end
							3'd2: begin n_ea = {db, ea0[7:0]}; n_addr = n_ea; end
							3'd3: begin
								lo8 = ea0[7:0] + 8'd1;
								n_addr = {ea0[15:8], lo8}; n_ea = {8'h00, db};
							end
							default: begin
								n_pc = {db, ea0[7:0]}; n_addr = n_pc; n_fetch = 1'b1;
							end
						endcase
					end
					M_PUSH: begin
						if (stp == 3'd0) begin
							n_addr = n_pc;
						end else if (stp == 3'd1) begin
							n_addr = {STACK_HI, s_q}; n_s = s_q - 8'd1;
							n_dl = (dec.op == O_A) ? a_q : (p_q | PUSH_BU);
							n_wr = 1'b1;
						end else begin
							n_addr = n_pc; n_fetch = 1'b1;
						end
					end
					M_PULL: begin
						if (stp == 3'd0) begin
							n_addr = n_pc;
						end else if (stp == 3'd1) begin
							n_addr = {STACK_HI, s_q}; n_s = s_q + 8'd1;
						end else if (stp == 3'd2) begin
							n_addr = {STACK_HI, s_q};
						end else begin
							if (dec.op == O_A) begin
								n_a = db; n_p = set_nz(p_q, db);
							end else begin
								n_p = (db & PULL_MSK) | FLAG_B;
							end
							n_addr = n_pc; n_fetch = 1'b1;
						end
					end
					default: begin
						// memory operand modes: address phase, then data phase
						case (dec.mode)
							M_IMM: len = 3'd1;
							M_ZP: len = 3'd2;
							M_ZPX, M_ZPY, M_ABS: len = 3'd3;
							M_ABSX, M_ABSY: len = 3'd4;
							default: len = 3'd5;
						endcase
						if (stp < len) begin
							if (stp == 3'd0) begin
								n_addr = n_pc; n_pc = n_pc + 16'd1;
							end else if (dec.mode == M_ZP) begin
								n_addr = {8'h00, db};
							end else if (dec.mode == M_ZPX || dec.mode == M_ZPY) begin
								if (stp == 3'd1) begin
									n_ea = {8'h00, db}; n_addr = n_ea;
								end else begin
									lo8 = ea0[7:0] + idx; n_addr = {8'h00, lo8};
								end
							end else if (dec.mode == M_ABS || dec.mode == M_ABSX ||
									dec.mode == M_ABSY) begin
								if (stp == 3'd1) begin
									n_addr = n_pc; n_pc = n_pc + 16'd1;
									n_ea = {8'h00, db};
								end else if (stp == 3'd2) begin
									tmp = {db, ea0[7:0]};
									n_ea = tmp;
									lo_sum = {1'b0, tmp[7:0]} + {1'b0, idx};
									if (dec.mode == M_ABS) begin
										n_addr = tmp;
									end else begin
										n_addr = {tmp[15:8], lo_sum[7:0]};
										if (!is_wr && !is_rmw && !lo_sum[8]) adv = 3'd2;
									end
								end else begin
									n_addr = ea0 + {8'h00, idx};
								end
							end else if (dec.mode == M_IZX) begin
								if (stp == 3'd1) begin
									n_ea = {8'h00, db}; n_addr = n_ea;
								end else if (stp == 3'd2) begin
									lo8 = ea0[7:0] + x_q;
									n_ea = {8'h00, lo8}; n_addr = n_ea;
								end else if (stp == 3'd3) begin
									lo8 = ea0[7:0] + 8'd1;
									n_addr = {8'h00, lo8}; n_ea = {8'h00, db};
								end else begin
									n_addr = {db, ea0[7:0]};
								end
							end else begin
								if (stp == 3'd1) begin
									n_ea = {8'h00, db}; n_addr = n_ea;
								end else if (stp == 3'd2) begin
									lo8 = ea0[7:0] + 8'd1;
									n_addr = {8'h00, lo8}; n_ea = {8'h00, db};
								end else if (stp == 3'd3) begin
									tmp = {db, ea0[7:0]};
									n_ea = tmp;
									lo_sum = {1'b0, tmp[7:0]} + {1'b0, y_q};
									n_addr = {tmp[15:8], lo_sum[7:0]};
									if (!is_wr && !is_rmw && !lo_sum[8]) adv = 3'd2;
								end else begin
									n_addr = ea0 + {8'h00, y_q};
								end
							end
							if (stp == len - 3'd1 && is_wr) begin
								n_dl = (dec.op == O_STA) ? a_q : x_q;
								n_wr = 1'b1;
							end
						end else begin
							ms = {5'd0, stp - len};
							if (is_wr) begin
								n_addr = n_pc; n_fetch = 1'b1;
							end else if (is_rmw) begin
								if (ms == 8'd0) begin
									n_wr = 1'b1;
								end else if (ms == 8'd1) begin
									if (dec.op == O_ASL) begin
										n_dl = {db[6:0], 1'b0};
										n_p = set_nz(p_q, n_dl);
										n_p[0] = db[7];
									end else begin
										n_dl = db + 8'd1;
										n_p = set_nz(p_q, n_dl);
									end
									n_wr = 1'b1;
								end else begin
									n_addr = n_pc; n_fetch = 1'b1;
								end
							end else begin
								case (dec.op)
									O_ORA: begin n_a = a_q | db; n_p = set_nz(p_q, n_a); end
									O_EOR: begin n_a = a_q ^ db; n_p = set_nz(p_q, n_a); end
									O_LDA: begin n_a = db; n_p = set_nz(p_q, db); end
									O_LDX: begin n_x = db; n_p = set_nz(p_q, db); end
									O_LDY: begin n_y = db; n_p = set_nz(p_q, db); end
									O_BIT: n_p = {db[7:6], p_q[5:2], ((a_q & db) == 8'h00),
										p_q[0]};
									default: ;
								endcase
								n_addr = n_pc; n_fetch = 1'b1;
							end
						end
					end
				endcase
				n_step = stp + adv;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= RESET_A; x_q <= '0; y_q <= '0; s_q <= RESET_S; p_q <= RESET_P;
			opc_q <= '0; step_q <= '0; pc_q <= '0; ea_q <= '0; addr_q <= '0;
			dl_q <= '0; wr_q <= 1'b0; fetch_q <= 1'b1; stop_q <= 1'b0;
		end else begin
			a_q <= n_a; x_q <= n_x; y_q <= n_y; s_q <= n_s; p_q <= n_p;
			opc_q <= n_opc; step_q <= n_step; pc_q <= n_pc; ea_q <= n_ea;
			addr_q <= n_addr; dl_q <= n_dl; wr_q <= n_wr; fetch_q <= n_fetch;
			stop_q <= n_stop;
		end
	end

	assign res.bus_address  = addr_q;
	assign res.write_data   = wr_q ? dl_q : 8'h00;
	assign res.write_strobe = wr_q;
	assign res.opcode_fetch = fetch_q;
	assign res.halted       = stop_q;

endmodule

// ----- hw/rtl/cpu_6502_cycle_stepped_core.sv -----
// ----------------------------------------------------------------------------
// cpu_6502_cycle_stepped_core
// Cycle-stepped 6502 subset: one bus cycle in, one bus cycle out.
// ----------------------------------------------------------------------------
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+--------------------------------
//  item     | item_valid   | item_stall   | item   (read_data, ready_req)
//  result   | result_valid | result_stall | result (address, data, strobes)
//
// One transaction per clock while the result is not stalled: an item waits in
// the input register and is executed into the CPU state when it fires; the state
// registers are the result register, so the result is presented from them once
// the item has fired.
// Reset puts the core at an opcode fetch from address 0x0000, A = 0xAA,
// S = 0xFD, P = I|B|Z.
// A stalled result holds the state; the input register then stalls too.
// ----------------------------------------------------------------------------
module cpu_6502_cycle_stepped_core import c6502_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic  item_valid_s1;
	item_t item_s1;
	logic  result_valid_q;
	logic  advance;
	logic  fire;

	// the result slot frees when empty or being taken this cycle
	assign advance    = !result_valid_q || !result_stall;
	assign fire       = item_valid_s1 && advance;
	assign item_stall = item_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1  <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (!item_stall) item_valid_s1 <= item_valid;
			if (advance) result_valid_q <= item_valid_s1;
		end
	end

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) item_s1 <= item;
	end

	// one processor cycle per fired transaction, unless halted or a read lacks ready_req
	c6502_exec u_exec (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(fire),
		.item_in(item_s1),
		.res    (result)
	);

	assign result_valid = result_valid_q;

endmodule

// ----- hw/rtl/c6502_checker.sv -----
// ----------------------------------------------------------------------------
// c6502_checker
// Port-level checks of the 6502 core, bound onto the top level.
// ----------------------------------------------------------------------------
`include "cpu_6502_cycle_stepped_core_macros.svh"

module c6502_checker import c6502_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	`C6502_ASSERT_NEXT(a_hold, result_valid && result_stall, $stable(result), "stalled result changed")
	`C6502_ASSERT_NEXT(a_halt_sticky, result.halted, result.halted, "halt cleared without reset")
	`C6502_ASSERT(a_halt_quiet, !result.halted || (!result.write_strobe && !result.opcode_fetch), "halted core drives a write or fetch")
	`C6502_ASSERT(a_wr_fetch, !(result.write_strobe && result.opcode_fetch), "write cycle marked as opcode fetch")
	`C6502_ASSERT(a_no_stall_empty, result_valid || !item_stall, "input stalled with empty result slot")

endmodule

bind cpu_6502_cycle_stepped_core c6502_checker u_c6502_checker (.*);
